// File: rtl/rba_pkg.sv
// Shared constants, status codes and result types for the ring byte allocator.
package rba_pkg;

  localparam int RING_BYTES = 4096;
  localparam int ALIGN      = 8;
  localparam int FIELD_W    = 13;
  localparam int PTR_W      = $clog2(RING_BYTES + 1);
  localparam int ALIGN_W    = $clog2(ALIGN);
  localparam int STRIDE_W   = FIELD_W + 1;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_NO_SPACE       = 2'd1,
    ST_NOT_RING_START = 2'd2,
    ST_NOT_FREE_END   = 2'd3
  } status_t;

  typedef struct packed {
    logic [PTR_W-1:0] free_start;
    logic [PTR_W-1:0] free_limit;
  } rba_ptrs_t;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] grant_begin;
    logic [FIELD_W-1:0] grant_end;
    logic [FIELD_W-1:0] granted_bytes;
    logic [FIELD_W-1:0] free_bytes;
  } rba_result_t;

endpackage

// File: rtl/rba_step.sv
// Combinational allocate/release step: next free pointers and the result item.
module rba_step import rba_pkg::*; (
  input  logic               mode,
  input  logic [FIELD_W-1:0] request_bytes,
  input  logic [FIELD_W-1:0] block_begin,
  input  logic [FIELD_W-1:0] block_end,
  input  rba_ptrs_t          ptrs,
  output rba_ptrs_t          ptrs_nxt,
  output rba_result_t        result
);

  localparam logic [PTR_W-1:0]    RING_P    = PTR_W'(RING_BYTES);
  localparam logic [STRIDE_W-1:0] ALIGN_M1  = STRIDE_W'(ALIGN - 1);
  localparam logic [STRIDE_W:0]   RING_E    = (STRIDE_W + 1)'(RING_BYTES);

  function automatic logic [PTR_W-1:0] fcount(input logic [PTR_W-1:0] s,
                                              input logic [PTR_W-1:0] l);
    if (s <= l) begin
      return l - s;
    end
    return RING_P - (s - l);
  endfunction

  logic [STRIDE_W-1:0] round_sum;
  logic [STRIDE_W-1:0] stride;
  logic [PTR_W-1:0]    cnt_cur;
  logic [PTR_W-1:0]    s0;
  logic [PTR_W-1:0]    room;
  logic [PTR_W-1:0]    take;
  logic [PTR_W-1:0]    g_end;
  logic [PTR_W-1:0]    g_bytes;
  logic [PTR_W-1:0]    rel_end_sat;
  status_t             status;

  assign round_sum = {1'b0, request_bytes} + ALIGN_M1;
  assign stride    = (round_sum >> ALIGN_W) << ALIGN_W;
  assign cnt_cur   = fcount(ptrs.free_start, ptrs.free_limit);
  assign s0        = (ptrs.free_start == RING_P) ? '0 : ptrs.free_start;
  assign room      = RING_P - s0;
  assign rel_end_sat = ((STRIDE_W + 1)'(block_end) > RING_E) ? RING_P : PTR_W'(block_end);

  always_comb begin
    status   = ST_OK;
    ptrs_nxt = ptrs;
    take     = '0;
    g_end    = '0;
    g_bytes  = '0;
    result.grant_begin   = '0;
    result.grant_end     = '0;
    result.granted_bytes = '0;
    if (!mode) begin
      if (stride > STRIDE_W'(cnt_cur)) begin
        status = ST_NO_SPACE;
      end else if (stride != '0) begin
        if (s0 < ptrs.free_limit) begin
          g_end   = s0 + PTR_W'(stride);
          g_bytes = PTR_W'(request_bytes);
          ptrs_nxt.free_start = g_end;
        end else begin
          take    = (STRIDE_W'(room) > stride) ? PTR_W'(stride) : room;
          g_end   = s0 + take;
          g_bytes = (STRIDE_W'(take) < STRIDE_W'(request_bytes)) ? take
                                                                 : PTR_W'(request_bytes);
          ptrs_nxt.free_start = (g_end >= RING_P) ? '0 : g_end;
        end
        result.grant_begin   = FIELD_W'(s0);
        result.grant_end     = FIELD_W'(g_end);
        result.granted_bytes = FIELD_W'(g_bytes);
      end
    end else begin
      if (ptrs.free_limit == RING_P) begin
        if (block_begin != '0) begin
          status = ST_NOT_RING_START;
        end
      end else if ((STRIDE_W + 1)'(block_begin) != (STRIDE_W + 1)'(ptrs.free_limit)) begin
        status = ST_NOT_FREE_END;
      end
      if (status == ST_OK) begin
        ptrs_nxt.free_limit = rel_end_sat;
      end
    end
    result.status     = status;
    result.free_bytes = FIELD_W'(fcount(ptrs_nxt.free_start, ptrs_nxt.free_limit));
  end

endmodule

// File: rtl/ring_byte_allocator.sv
// Ring byte allocator top: input register, step logic, free pointers, result register.
// Path: input register, step logic, result register; free pointers update as an item
// leaves the input register. Throughput: one item per cycle unless the output is stalled.
// Reset: free start to 0, free limit to the ring size, both stages empty; no clearing pass.
module ring_byte_allocator import rba_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [FIELD_W-1:0] in_request_bytes,
  input  logic [FIELD_W-1:0] in_block_begin,
  input  logic [FIELD_W-1:0] in_block_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [FIELD_W-1:0] out_grant_begin,
  output logic [FIELD_W-1:0] out_grant_end,
  output logic [FIELD_W-1:0] out_granted_bytes,
  output logic [FIELD_W-1:0] out_free_bytes
);

  logic               s1_valid_r;
  logic               s1_valid_nxt;
  logic               s1_mode_r;
  logic [FIELD_W-1:0] s1_req_r;
  logic [FIELD_W-1:0] s1_begin_r;
  logic [FIELD_W-1:0] s1_end_r;
  logic               s1_adv;
  logic               out_valid_r;
  logic               out_valid_nxt;
  rba_result_t        out_res_r;
  rba_result_t        step_res;
  rba_ptrs_t          ptrs_r;
  rba_ptrs_t          ptrs_nxt;

  rba_step u_step (
    .mode          (s1_mode_r),
    .request_bytes (s1_req_r),
    .block_begin   (s1_begin_r),
    .block_end     (s1_end_r),
    .ptrs          (ptrs_r),
    .ptrs_nxt      (ptrs_nxt),
    .result        (step_res)
  );

  assign s1_adv        = !out_valid_r || !out_stall;
  assign in_stall      = s1_valid_r && !s1_adv;
  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r         <= 1'b0;
      out_valid_r        <= 1'b0;
      ptrs_r.free_start  <= '0;
      ptrs_r.free_limit  <= PTR_W'(RING_BYTES);
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_valid_r && s1_adv) begin
        ptrs_r <= ptrs_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_mode_r  <= in_mode;
      s1_req_r   <= in_request_bytes;
      s1_begin_r <= in_block_begin;
      s1_end_r   <= in_block_end;
    end
    if (s1_valid_r && s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_grant_begin   = out_res_r.grant_begin;
  assign out_grant_end     = out_res_r.grant_end;
  assign out_granted_bytes = out_res_r.granted_bytes;
  assign out_free_bytes    = out_res_r.free_bytes;

  a_ptrs_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (ptrs_r.free_start <= PTR_W'(RING_BYTES)) && (ptrs_r.free_limit <= PTR_W'(RING_BYTES)))
    else $error("free pointer beyond ring end");

  a_ptrs_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_valid_r && s1_adv) |=> $stable(ptrs_r))
    else $error("free pointers moved without an item");

  a_refuse_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.status != ST_OK) |->
      (out_res_r.grant_end == '0) && (out_res_r.granted_bytes == '0))
    else $error("grant reported on a refused item");

  a_grant_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (PTR_W'(out_res_r.grant_end) <= PTR_W'(RING_BYTES)) &&
                    (out_res_r.grant_begin <= out_res_r.grant_end))
    else $error("grant outside ring");

  a_free_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> PTR_W'(out_res_r.free_bytes) <= PTR_W'(RING_BYTES))
    else $error("free byte count exceeds ring");

endmodule
